### hw/rtl/assert_macros.svh
// shared assertion macros for the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define HCB_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hcb assertion failed");

// next-cycle implication, disabled during reset
`define HCB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hcb assertion failed");

// next-cycle implication that also holds across reset
`define HCB_ASSERT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("hcb assertion failed");

`endif

### hw/rtl/hcb_pkg.sv
// ----------------------------------------------------------------------------
// hcb_pkg
// types and codes shared by the huffman code builder files
// ----------------------------------------------------------------------------
`default_nettype none

package hcb_pkg;

  localparam int DEF_ALPHABET_SIZE   = 256;
  localparam int DEF_MAX_TOTAL_COUNT = 65535;
  localparam int DEF_MAX_CODE_LEN    = 32;
  localparam int LEAF_COUNT_MAX      = 65535;

  localparam logic [1:0] FUNC_COUNT  = 2'd0;
  localparam logic [1:0] FUNC_ENCODE = 2'd1;
  localparam logic [1:0] FUNC_DECODE = 2'd2;
  localparam logic [1:0] FUNC_CLEAR  = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_BUILT = 3'd1;
  localparam logic [2:0] ST_EMPTY     = 3'd2;
  localparam logic [2:0] ST_TOO_LONG  = 3'd3;
  localparam logic [2:0] ST_SATURATED = 3'd4;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] symbol_in;
    logic       bit_in;
    logic       last_symbol;
  } req_t;

  typedef struct packed {
    logic [31:0] code_bits;
    logic [5:0]  code_length;
    logic [7:0]  symbol_out;
    logic        symbol_valid;
    logic [2:0]  status;
  } rsp_t;

endpackage

`default_nettype wire

### hw/rtl/hcb_ram.sv
// ----------------------------------------------------------------------------
// hcb_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module hcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hw/rtl/huffman_code_builder_codec.sv
// count, encode and decode words: taken one at a time in idle, result registered out
// of the execute state; the node and tree rams are read in one state then written
// tree build after last_symbol: load the leaves, then per merge two scans of up to
// 2A-2 nodes, each ending in a take, and a merge; then read, fetch, left and right
// writes per internal node for codes, and a finish state that answers the last count
// reset (synchronous, active high) and clear words sweep the A leaf counts
`default_nettype none

module huffman_code_builder_codec #(
  parameter int ALPHABET_SIZE   = hcb_pkg::DEF_ALPHABET_SIZE,
  parameter int MAX_TOTAL_COUNT = hcb_pkg::DEF_MAX_TOTAL_COUNT,
  parameter int MAX_CODE_LEN    = hcb_pkg::DEF_MAX_CODE_LEN
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire hcb_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output hcb_pkg::rsp_t      rsp
);

  localparam int NODES = 2 * ALPHABET_SIZE - 1;
  localparam int NW    = $clog2(NODES);
  localparam int WW    = $clog2(MAX_TOTAL_COUNT + 1);
  localparam int ML    = MAX_CODE_LEN;
  localparam int LW    = $clog2(MAX_CODE_LEN + 2);
  localparam int CNTW  = $clog2(ALPHABET_SIZE + 1);
  localparam int NDW   = WW + 1;
  localparam int TDW   = 2 * NW + ML + LW;
  localparam int CWX   = (ML > 32) ? ML : 32;

  localparam logic [NW-1:0] A_IDX   = NW'(ALPHABET_SIZE);
  localparam logic [NW-1:0] A_LAST  = NW'(ALPHABET_SIZE - 1);
  localparam logic [LW-1:0] LEN_SAT = LW'(MAX_CODE_LEN + 1);
  localparam logic [LW-1:0] LEN_MAX = LW'(MAX_CODE_LEN);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_EXEC  = 4'd2;
  localparam logic [3:0] S_INIT  = 4'd3;
  localparam logic [3:0] S_SCAN  = 4'd4;
  localparam logic [3:0] S_TAKE  = 4'd5;
  localparam logic [3:0] S_MERGE = 4'd6;
  localparam logic [3:0] S_WRD   = 4'd7;
  localparam logic [3:0] S_WGET  = 4'd8;
  localparam logic [3:0] S_WL    = 4'd9;
  localparam logic [3:0] S_WR    = 4'd10;
  localparam logic [3:0] S_FIN   = 4'd11;

  logic [3:0]      state;
  hcb_pkg::req_t   item;
  logic [NW-1:0]   idx;
  logic [NW-1:0]   scan_addr;
  logic            rd_vld;
  logic [NW-1:0]   rd_idx;
  logic [CNTW-1:0] cnt_n;
  logic [CNTW-1:0] merges;
  logic [NW-1:0]   last_leaf;
  logic [NW-1:0]   next_node;
  logic            found;
  logic            take_second;
  logic [NW-1:0]   best_idx;
  logic [WW-1:0]   best_w;
  logic [NW-1:0]   a_idx;
  logic [WW-1:0]   a_w;
  logic [WW-1:0]   total;
  logic            tree_built;
  logic [NW-1:0]   cursor;
  logic [NW-1:0]   root;
  logic [2:0]      pend_status;
  logic            too_long;
  logic            clr_reply;
  logic [NW-1:0]   w_l;
  logic [NW-1:0]   w_r;
  logic [ML-1:0]   w_cw;
  logic [LW-1:0]   w_len;

  logic            rsp_valid_next;
  hcb_pkg::rsp_t   rsp_next;

  logic            node_we;
  logic [NW-1:0]   node_waddr;
  logic [NDW-1:0]  node_wdata;
  logic [NW-1:0]   node_raddr;
  logic [NDW-1:0]  node_rdata;
  logic            tree_we;
  logic [NW-1:0]   tree_waddr;
  logic [TDW-1:0]  tree_wdata;
  logic [NW-1:0]   tree_raddr;
  logic [TDW-1:0]  tree_rdata;

  logic            accept;
  logic [NW-1:0]   dec_addr;
  logic [NW-1:0]   item_sym;
  logic            sym_ok;
  logic            sat;
  logic [WW-1:0]   leaf_w;
  logic [NW-1:0]   t_left;
  logic [NW-1:0]   t_right;
  logic [ML-1:0]   t_cw;
  logic [LW-1:0]   t_cl;
  logic [LW-1:0]   len_c;
  logic [NW-1:0]   dec_nxt;
  logic [CWX-1:0]  cw_ext;

  hcb_ram #(.WIDTH(NDW), .DEPTH(NODES)) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (node_wdata),
    .raddr (node_raddr),
    .rdata (node_rdata)
  );

  hcb_ram #(.WIDTH(TDW), .DEPTH(NODES)) u_tree_ram (
    .clk   (clk),
    .we    (tree_we),
    .waddr (tree_waddr),
    .wdata (tree_wdata),
    .raddr (tree_raddr),
    .rdata (tree_rdata)
  );

  assign req_stall = !((state == S_IDLE) && (!rsp_valid || !rsp_stall));
  assign accept    = req_valid && !req_stall;

  // tree entry: left, right, code word, code length
  assign t_left  = tree_rdata[TDW-1 -: NW];
  assign t_right = tree_rdata[TDW-NW-1 -: NW];
  assign t_cw    = tree_rdata[ML+LW-1 : LW];
  assign t_cl    = tree_rdata[LW-1:0];
  assign len_c   = (t_cl >= LEN_SAT) ? LEN_SAT : t_cl + LW'(1);
  assign cw_ext  = CWX'(t_cw);

  assign leaf_w   = node_rdata[WW-1:0];
  assign item_sym = NW'(item.symbol_in);
  assign sym_ok   = 32'(item.symbol_in) < 32'(ALPHABET_SIZE);
  assign sat      = (32'(total) >= 32'(MAX_TOTAL_COUNT)) ||
                    (32'(leaf_w) >= 32'(hcb_pkg::LEAF_COUNT_MAX));
  assign dec_addr = ((cursor < A_IDX) || (cursor > root)) ? root : cursor;
  assign dec_nxt  = item.bit_in ? t_right : t_left;

  always_comb begin
    node_we    = 1'b0;
    node_waddr = '0;
    node_wdata = '0;
    node_raddr = '0;
    tree_we    = 1'b0;
    tree_waddr = '0;
    tree_wdata = '0;
    tree_raddr = '0;
    unique case (state)
      S_CLR: begin
        node_we    = 1'b1;
        node_waddr = idx;
      end
      S_IDLE: begin
        node_raddr = NW'(req.symbol_in);
        tree_raddr = (req.func == hcb_pkg::FUNC_DECODE) ? dec_addr : NW'(req.symbol_in);
      end
      S_EXEC: begin
        if ((item.func == hcb_pkg::FUNC_COUNT) && sym_ok && !sat) begin
          node_we    = 1'b1;
          node_waddr = item_sym;
          node_wdata = {node_rdata[WW], leaf_w + WW'(1)};
        end
      end
      S_INIT: begin
        node_raddr = idx;
        if (rd_vld) begin
          node_we    = 1'b1;
          node_waddr = rd_idx;
          node_wdata = {|leaf_w, leaf_w};
          tree_we    = 1'b1;
          tree_waddr = rd_idx;
        end else if ((idx == A_IDX) && (cnt_n == CNTW'(1))) begin
          // lone symbol gets the one-bit code 0
          tree_we    = 1'b1;
          tree_waddr = last_leaf;
          tree_wdata = TDW'(1);
        end
      end
      S_SCAN: begin
        node_raddr = scan_addr;
      end
      S_TAKE: begin
        node_we    = 1'b1;
        node_waddr = best_idx;
        node_wdata = {1'b0, best_w};
      end
      S_MERGE: begin
        node_we    = 1'b1;
        node_waddr = next_node;
        node_wdata = {1'b1, a_w + best_w};
        tree_we    = 1'b1;
        tree_waddr = next_node;
        tree_wdata = {a_idx, best_idx, {(ML + LW){1'b0}}};
      end
      S_WRD: begin
        tree_raddr = idx;
      end
      S_WGET: begin
        tree_raddr = t_left;
      end
      S_WL: begin
        tree_we    = 1'b1;
        tree_waddr = w_l;
        tree_wdata = {t_left, t_right, w_cw, w_len};
        tree_raddr = w_r;
      end
      S_WR: begin
        tree_we    = 1'b1;
        tree_waddr = w_r;
        tree_wdata = {t_left, t_right, w_cw | ML'(1), w_len};
      end
      default: begin
      end
    endcase
  end

  // result word: a stalled word holds, new words load only while none is out
  always_comb begin
    rsp_valid_next = rsp_valid && rsp_stall;
    rsp_next       = rsp;
    unique case (state)
      S_CLR: begin
        if ((idx == A_LAST) && clr_reply) begin
          rsp_valid_next = 1'b1;
          rsp_next       = '0;
        end
      end
      S_EXEC: begin
        rsp_next = '0;
        unique case (item.func)
          hcb_pkg::FUNC_COUNT: begin
            rsp_valid_next = !item.last_symbol;
            if (sym_ok && sat) begin
              rsp_next.status = hcb_pkg::ST_SATURATED;
            end
          end
          hcb_pkg::FUNC_ENCODE: begin
            rsp_valid_next = 1'b1;
            if (!tree_built) begin
              rsp_next.status = hcb_pkg::ST_NOT_BUILT;
            end else if (sym_ok) begin
              rsp_next.code_bits   = cw_ext[31:0];
              rsp_next.code_length = 6'(t_cl);
            end
          end
          hcb_pkg::FUNC_DECODE: begin
            rsp_valid_next = 1'b1;
            if (!tree_built) begin
              rsp_next.status = hcb_pkg::ST_NOT_BUILT;
            end else if (root < A_IDX) begin
              rsp_next.symbol_out   = 8'(root);
              rsp_next.symbol_valid = 1'b1;
            end else if (dec_nxt < A_IDX) begin
              rsp_next.symbol_out   = 8'(dec_nxt);
              rsp_next.symbol_valid = 1'b1;
            end
          end
          hcb_pkg::FUNC_CLEAR: begin
            rsp_valid_next = 1'b0;
          end
        endcase
      end
      S_INIT: begin
        if ((idx == A_IDX) && !rd_vld && (cnt_n <= CNTW'(1))) begin
          rsp_valid_next  = 1'b1;
          rsp_next        = '0;
          rsp_next.status = (cnt_n == '0) ? hcb_pkg::ST_EMPTY : pend_status;
        end
      end
      S_FIN: begin
        rsp_valid_next  = 1'b1;
        rsp_next        = '0;
        rsp_next.status = too_long ? hcb_pkg::ST_TOO_LONG : pend_status;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      idx        <= '0;
      rd_vld     <= 1'b0;
      total      <= '0;
      tree_built <= 1'b0;
      cursor     <= '0;
      root       <= '0;
      clr_reply  <= 1'b0;
      rsp_valid  <= 1'b0;
      rsp        <= '0;
    end else begin
      rsp_valid <= rsp_valid_next;
      rsp       <= rsp_next;
      unique case (state)
        S_CLR: begin
          idx <= idx + NW'(1);
          if (idx == A_LAST) begin
            state     <= S_IDLE;
            clr_reply <= 1'b0;
          end
        end
        S_IDLE: begin
          if (accept) begin
            item  <= req;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          unique case (item.func)
            hcb_pkg::FUNC_COUNT: begin
              tree_built  <= 1'b0;
              cursor      <= '0;
              pend_status <= (sym_ok && sat) ? hcb_pkg::ST_SATURATED : hcb_pkg::ST_OK;
              if (sym_ok && !sat) begin
                total <= total + WW'(1);
              end
              if (item.last_symbol) begin
                state  <= S_INIT;
                idx    <= '0;
                rd_vld <= 1'b0;
                cnt_n  <= '0;
              end else begin
                state <= S_IDLE;
              end
            end
            hcb_pkg::FUNC_ENCODE: begin
              state <= S_IDLE;
            end
            hcb_pkg::FUNC_DECODE: begin
              state <= S_IDLE;
              if (tree_built && (root >= A_IDX)) begin
                cursor <= (dec_nxt < A_IDX) ? root : dec_nxt;
              end
            end
            hcb_pkg::FUNC_CLEAR: begin
              state      <= S_CLR;
              idx        <= '0;
              clr_reply  <= 1'b1;
              total      <= '0;
              tree_built <= 1'b0;
              cursor     <= '0;
              root       <= '0;
            end
          endcase
        end
        S_INIT: begin
          if (idx != A_IDX) begin
            idx <= idx + NW'(1);
          end
          rd_vld <= (idx != A_IDX);
          rd_idx <= idx;
          if (rd_vld && (leaf_w != '0)) begin
            cnt_n     <= cnt_n + CNTW'(1);
            last_leaf <= rd_idx;
          end
          if ((idx == A_IDX) && !rd_vld) begin
            if (cnt_n == '0) begin
              state <= S_IDLE;
            end else if (cnt_n == CNTW'(1)) begin
              state      <= S_IDLE;
              root       <= last_leaf;
              cursor     <= last_leaf;
              tree_built <= 1'b1;
            end else begin
              state       <= S_SCAN;
              next_node   <= A_IDX;
              merges      <= cnt_n - CNTW'(1);
              scan_addr   <= '0;
              found       <= 1'b0;
              take_second <= 1'b0;
            end
          end
        end
        S_SCAN: begin
          if (scan_addr != next_node) begin
            scan_addr <= scan_addr + NW'(1);
          end
          rd_vld <= (scan_addr != next_node);
          rd_idx <= scan_addr;
          // strict compare keeps the lower index on a tie
          if (rd_vld && node_rdata[WW] && (!found || (leaf_w < best_w))) begin
            found    <= 1'b1;
            best_idx <= rd_idx;
            best_w   <= leaf_w;
          end
          if ((scan_addr == next_node) && !rd_vld) begin
            state <= S_TAKE;
          end
        end
        S_TAKE: begin
          if (!take_second) begin
            a_idx       <= best_idx;
            a_w         <= best_w;
            take_second <= 1'b1;
            scan_addr   <= '0;
            found       <= 1'b0;
            state       <= S_SCAN;
          end else begin
            state <= S_MERGE;
          end
        end
        S_MERGE: begin
          next_node <= next_node + NW'(1);
          merges    <= merges - CNTW'(1);
          if (merges == CNTW'(1)) begin
            root     <= next_node;
            idx      <= next_node;
            too_long <= 1'b0;
            state    <= S_WRD;
          end else begin
            scan_addr   <= '0;
            found       <= 1'b0;
            take_second <= 1'b0;
            state       <= S_SCAN;
          end
        end
        S_WRD: begin
          state <= S_WGET;
        end
        S_WGET: begin
          w_l   <= t_left;
          w_r   <= t_right;
          w_cw  <= t_cw << 1;
          w_len <= len_c;
          if (len_c > LEN_MAX) begin
            too_long <= 1'b1;
          end
          state <= S_WL;
        end
        S_WL: begin
          state <= S_WR;
        end
        S_WR: begin
          if (idx == A_IDX) begin
            state <= S_FIN;
          end else begin
            idx   <= idx - NW'(1);
            state <= S_WRD;
          end
        end
        S_FIN: begin
          state <= S_IDLE;
          if (!too_long) begin
            tree_built <= 1'b1;
            cursor     <= root;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/hcb_checker.sv
// ----------------------------------------------------------------------------
// hcb_checker
// port-level checks on the huffman code builder, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module hcb_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          req_valid,
  input wire logic          req_stall,
  input wire hcb_pkg::req_t req,
  input wire logic          rsp_valid,
  input wire logic          rsp_stall,
  input wire hcb_pkg::rsp_t rsp
);

  logic req_take;

  assign req_take = req_valid && !req_stall;

  // a held result word stays put
  `HCB_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

  // no byte without the valid flag
  `HCB_ASSERT_NOW(a_sym_flag, clk, rst, rsp_valid && !rsp.symbol_valid, rsp.symbol_out == 8'd0)

  // any error status comes with an empty code
  `HCB_ASSERT_NOW(a_err_code, clk, rst, rsp_valid && (rsp.status != hcb_pkg::ST_OK),
                  (rsp.code_length == 6'd0) && (rsp.code_bits == 32'd0))

  // the clearing sweep after reset holds off input
  `HCB_ASSERT_ALWAYS(a_rst_stall, clk, rst, req_stall)

  // an accepted word holds off the next one while it is worked on
  `HCB_ASSERT_NEXT(a_one_at_time, clk, rst, req_take, req_stall)

endmodule

bind huffman_code_builder_codec hcb_checker u_hcb_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

`default_nettype wire

### dv/hcb_scoreboard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcb_scoreboard
// watches both channels of the huffman code builder, keeps its own copy of
// the frequency table and code tree, and checks every response word
// ----------------------------------------------------------------------------
`default_nettype none

module hcb_scoreboard (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  input  wire logic          req_stall,
  input  wire hcb_pkg::req_t req,
  input  wire logic          rsp_valid,
  input  wire logic          rsp_stall,
  input  wire hcb_pkg::rsp_t rsp,
  output int                 errors,
  output int                 pending
);

  localparam int A = hcb_pkg::DEF_ALPHABET_SIZE;

  int unsigned   freq [A];
  int unsigned   weight [2*A-1];
  int unsigned   left_of [A-1];
  int unsigned   right_of [A-1];
  logic [31:0]   code_of [A];
  int unsigned   len_of [A];
  int unsigned   total;
  bit            built;
  int unsigned   cursor;
  int unsigned   root;
  hcb_pkg::rsp_t rsp_queue [$];

  function automatic void clear_model();
    for (int i = 0; i < A; i++) begin
      freq[i] = 0;
      code_of[i] = '0;
      len_of[i] = 0;
    end
    total = 0;
    built = 0;
    cursor = 0;
    root = 0;
  endfunction

  function automatic int unsigned pick_lightest(ref bit alive [2*A-1], input int unsigned lim);
    int unsigned best;
    bit found;
    best = 0;
    found = 0;
    for (int unsigned i = 0; i < lim; i++)
      if (alive[i] && (!found || weight[i] < weight[best])) begin
        best = i;
        found = 1;
      end
    alive[best] = 0;
    return best;
  endfunction

  function automatic logic [2:0] build_codes();
    bit          alive [2*A-1];
    logic [63:0] cw [2*A-1];
    int unsigned cl [2*A-1];
    int unsigned n, lastsym, nxt, a, b, l, r, ln;
    n = 0;
    lastsym = 0;
    built = 0;
    cursor = 0;
    for (int i = 0; i < 2*A-1; i++) begin
      alive[i] = 0;
      cw[i] = '0;
      cl[i] = 0;
    end
    for (int i = 0; i < A; i++) begin
      code_of[i] = '0;
      len_of[i] = 0;
      weight[i] = freq[i];
      if (freq[i] != 0) begin
        alive[i] = 1;
        n++;
        lastsym = i;
      end
    end
    if (n == 0) return hcb_pkg::ST_EMPTY;
    if (n == 1) begin
      len_of[lastsym] = 1;
      root = lastsym;
      cursor = lastsym;
      built = 1;
      return hcb_pkg::ST_OK;
    end
    nxt = A;
    for (int unsigned i = 0; i + 1 < n; i++) begin
      a = pick_lightest(alive, nxt);
      b = pick_lightest(alive, nxt);
      weight[nxt] = weight[a] + weight[b];
      left_of[nxt-A] = a;
      right_of[nxt-A] = b;
      alive[nxt] = 1;
      nxt++;
    end
    root = nxt - 1;
    // parents always sit above their children, so walk downward
    for (int unsigned nd = root; nd >= A; nd--) begin
      l = left_of[nd-A];
      r = right_of[nd-A];
      ln = cl[nd] < 255 ? cl[nd] + 1 : 255;
      cw[l] = cw[nd] << 1;
      cw[r] = (cw[nd] << 1) | 64'd1;
      cl[l] = ln;
      cl[r] = ln;
    end
    for (int i = 0; i < A; i++)
      if (cl[i] > hcb_pkg::DEF_MAX_CODE_LEN) return hcb_pkg::ST_TOO_LONG;
    for (int i = 0; i < A; i++) begin
      code_of[i] = cw[i][31:0];
      len_of[i] = cl[i];
    end
    cursor = root;
    built = 1;
    return hcb_pkg::ST_OK;
  endfunction

  function automatic hcb_pkg::rsp_t predict_word(hcb_pkg::req_t w);
    hcb_pkg::rsp_t e;
    logic [2:0] s;
    int unsigned cur, nx;
    e = '0;
    case (w.func)
      hcb_pkg::FUNC_COUNT: begin
        built = 0;
        cursor = 0;
        if (total >= hcb_pkg::DEF_MAX_TOTAL_COUNT ||
            freq[w.symbol_in] >= hcb_pkg::LEAF_COUNT_MAX) begin
          e.status = hcb_pkg::ST_SATURATED;
        end else begin
          freq[w.symbol_in]++;
          total++;
        end
        if (w.last_symbol) begin
          s = build_codes();
          if (s != hcb_pkg::ST_OK) e.status = s;
        end
      end
      hcb_pkg::FUNC_ENCODE: begin
        if (!built) e.status = hcb_pkg::ST_NOT_BUILT;
        else begin
          e.code_bits = code_of[w.symbol_in];
          e.code_length = 6'(len_of[w.symbol_in]);
        end
      end
      hcb_pkg::FUNC_DECODE: begin
        if (!built) e.status = hcb_pkg::ST_NOT_BUILT;
        else if (root < A) begin
          e.symbol_out = 8'(root);
          e.symbol_valid = 1;
        end else begin
          cur = cursor;
          if (cur < A || cur > root) cur = root;
          nx = w.bit_in ? right_of[cur-A] : left_of[cur-A];
          if (nx < A) begin
            e.symbol_out = 8'(nx);
            e.symbol_valid = 1;
            cursor = root;
          end else cursor = nx;
        end
      end
      default: clear_model();
    endcase
    return e;
  endfunction

  always @(posedge clk) begin
    hcb_pkg::rsp_t e;
    if (rst) begin
      clear_model();
      rsp_queue.delete();
      errors = 0;
    end else begin
      if (req_valid && !req_stall) rsp_queue.push_back(predict_word(req));
      if (rsp_valid && !rsp_stall) begin
        if (rsp_queue.size() == 0) begin
          errors++;
          $display("%0t: unexpected response word %h", $time, rsp);
        end else begin
          e = rsp_queue.pop_front();
          if (rsp.code_bits !== e.code_bits || rsp.code_length !== e.code_length ||
              rsp.symbol_out !== e.symbol_out || rsp.symbol_valid !== e.symbol_valid ||
              rsp.status !== e.status) begin
            errors++;
            $display("%0t: mismatch expected code %h len %0d sym %0d v %0d st %0d",
                     $time, e.code_bits, e.code_length, e.symbol_out, e.symbol_valid,
                     e.status);
            $display("%0t:            actual code %h len %0d sym %0d v %0d st %0d",
                     $time, rsp.code_bits, rsp.code_length, rsp.symbol_out,
                     rsp.symbol_valid, rsp.status);
          end
        end
      end
    end
    pending = rsp_queue.size();
  end

endmodule

`default_nettype wire

### dv/tb_huffman_code_builder_codec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_huffman_code_builder_codec
// drives count, encode, decode and clear words into the huffman code builder
// under random idling on both sides; the scoreboard checks every response
// ----------------------------------------------------------------------------
`default_nettype none

module tb_huffman_code_builder_codec;

  logic          clk = 0;
  logic          rst = 1;
  logic          req_valid = 0;
  logic          req_stall;
  hcb_pkg::req_t req = '0;
  logic          rsp_valid;
  logic          rsp_stall = 0;
  hcb_pkg::rsp_t rsp;
  int            errors, pending;
  int            snd_idle = 0;
  int            rcv_idle = 0;
  int            hold_left = 0;
  int            sent = 0;
  logic [7:0]    alphabet [$];

  always #5 clk = ~clk;

  huffman_code_builder_codec uut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  hcb_scoreboard chk (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .errors(errors), .pending(pending)
  );

  // receiver side; a long hold lets the block back up into its input
  always @(posedge clk) begin
    if (hold_left > 0) begin
      rsp_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else rsp_stall <= ($urandom_range(99) < rcv_idle);
  end

  task automatic put_word(input logic [1:0] f, input logic [7:0] s, input logic b,
                          input logic l);
    while ($urandom_range(99) < snd_idle) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= '{func: f, symbol_in: s, bit_in: b, last_symbol: l};
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // one message over 2 to 12 random bytes, then a burst of lookups mixed with count and clear words
  task automatic random_message();
    int k, m, r;
    k = $urandom_range(2, 12);
    alphabet.delete();
    for (int i = 0; i < k; i++) alphabet.push_back(8'($urandom_range(255)));
    m = $urandom_range(k, 30);
    for (int i = 0; i < m; i++)
      put_word(hcb_pkg::FUNC_COUNT, i < k ? alphabet[i] : alphabet[$urandom_range(k-1)],
               1'($urandom_range(1)), i == m - 1);
    repeat ($urandom_range(15, 40)) begin
      r = $urandom_range(99);
      if (r < 50)
        put_word(hcb_pkg::FUNC_DECODE, 8'($urandom_range(255)), 1'($urandom_range(1)),
                 1'($urandom_range(1)));
      else if (r < 85)
        put_word(hcb_pkg::FUNC_ENCODE,
                 r < 75 ? alphabet[$urandom_range(k-1)] : 8'($urandom_range(255)),
                 1'($urandom_range(1)), 1'($urandom_range(1)));
      else if (r < 95)
        put_word(hcb_pkg::FUNC_COUNT, 8'($urandom_range(255)), 1'($urandom_range(1)),
                 1'($urandom_range(1)));
      else
        put_word(hcb_pkg::FUNC_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)),
                 1'($urandom_range(1)));
    end
  endtask

  initial begin
    int f0, f1, f2, base;
    snd_idle = 30;
    rcv_idle = 82;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // lookups before anything is built
    put_word(hcb_pkg::FUNC_ENCODE, 8'd0, 1'b0, 1'b0);
    put_word(hcb_pkg::FUNC_DECODE, 8'd255, 1'b1, 1'b1);
    // a message of a single byte
    put_word(hcb_pkg::FUNC_COUNT, 8'd65, 1'b0, 1'b0);
    put_word(hcb_pkg::FUNC_COUNT, 8'd65, 1'b1, 1'b1);
    put_word(hcb_pkg::FUNC_ENCODE, 8'd65, 1'b0, 1'b0);
    put_word(hcb_pkg::FUNC_ENCODE, 8'd66, 1'b0, 1'b0);
    put_word(hcb_pkg::FUNC_DECODE, 8'd0, 1'b0, 1'b0);
    put_word(hcb_pkg::FUNC_DECODE, 8'd0, 1'b1, 1'b0);
    // counting again drops the built code
    put_word(hcb_pkg::FUNC_COUNT, 8'd0, 1'b0, 1'b0);
    put_word(hcb_pkg::FUNC_ENCODE, 8'd65, 1'b0, 1'b0);
    put_word(hcb_pkg::FUNC_COUNT, 8'd255, 1'b0, 1'b0);
    put_word(hcb_pkg::FUNC_COUNT, 8'd255, 1'b0, 1'b1);
    put_word(hcb_pkg::FUNC_ENCODE, 8'd0, 1'b0, 1'b0);
    put_word(hcb_pkg::FUNC_ENCODE, 8'd255, 1'b0, 1'b0);
    put_word(hcb_pkg::FUNC_ENCODE, 8'd65, 1'b0, 1'b0);
    put_word(hcb_pkg::FUNC_DECODE, 8'd0, 1'b1, 1'b0);
    put_word(hcb_pkg::FUNC_DECODE, 8'd0, 1'b0, 1'b0);
    put_word(hcb_pkg::FUNC_DECODE, 8'd0, 1'b0, 1'b0);
    put_word(hcb_pkg::FUNC_CLEAR, 8'd0, 1'b0, 1'b0);
    put_word(hcb_pkg::FUNC_ENCODE, 8'd255, 1'b0, 1'b0);

    // fibonacci weights give a deep, lopsided tree
    f0 = 1;
    f1 = 1;
    for (int s = 0; s < 12; s++) begin
      for (int i = 0; i < f0; i++) put_word(hcb_pkg::FUNC_COUNT, 8'(s * 21), 1'b0, 1'b0);
      f2 = f0 + f1;
      f0 = f1;
      f1 = f2;
    end
    put_word(hcb_pkg::FUNC_COUNT, 8'd250, 1'b0, 1'b1);
    for (int s = 0; s < 12; s++) put_word(hcb_pkg::FUNC_ENCODE, 8'(s * 21), 1'b0, 1'b0);
    repeat (30) put_word(hcb_pkg::FUNC_DECODE, 8'd0, 1'b1, 1'b0);
    put_word(hcb_pkg::FUNC_CLEAR, 8'd0, 1'b0, 1'b0);

    // every byte once: the full 256-leaf tree
    for (int s = 0; s < 256; s++) put_word(hcb_pkg::FUNC_COUNT, 8'(s), 1'b0, s == 255);
    for (int s = 0; s < 256; s += 17) put_word(hcb_pkg::FUNC_ENCODE, 8'(s), 1'b0, 1'b0);
    repeat (20) put_word(hcb_pkg::FUNC_DECODE, 8'd0, 1'($urandom_range(1)), 1'b0);
    drain();
    put_word(hcb_pkg::FUNC_CLEAR, 8'd0, 1'b0, 1'b0);

    base = sent;
    // long receiver hold while words keep coming
    hold_left = 300;
    random_message();
    drain();
    snd_idle = 82;
    rcv_idle = 30;
    while (sent - base < 120) random_message();
    drain();
    snd_idle = 0;
    rcv_idle = 0;
    while (sent - base < 217) random_message();
    drain();
    repeat (10) @(posedge clk);
    if (errors == 0) $display("** huffman_code_builder_codec: PASSED **");
    else $display("** huffman_code_builder_codec: FAILED **");
    $finish;
  end

  initial begin
    #10ms;
    $display("** huffman_code_builder_codec: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
